>>> hdl/tick_to_microsecond_converter_unit_assert.svh
`ifndef TICK_TO_MICROSECOND_CONVERTER_UNIT_ASSERT_SVH
`define TICK_TO_MICROSECOND_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, reset masked
`define TTUS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ttus assertion failed");

// next-cycle implication, reset masked
`define TTUS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ttus assertion failed");

`endif

>>> hdl/ttus_pkg.sv
`timescale 1ns / 1ps

package ttus_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned SHIFT_W = 7;
	localparam int unsigned POW_W = 84;
	localparam int unsigned MCNT_W = 3;

	localparam logic [DATA_W-1:0] FREQ_RESET = 64'd24000000;
	localparam logic [POW_W-1:0] POW_INIT = 84'd1000000 << 64;
	localparam logic [SHIFT_W-1:0] MAX_SHIFT = 7'd64;
	localparam logic [SHIFT_W-1:0] DIV_STEPS = 7'd64;
	localparam logic [MCNT_W-1:0] MUL_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIVIDE,
		ST_MUL,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic cfg_wr;
		logic start;
		logic srch_step;
		logic div_step;
		logic mul_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic derived;
		logic fit;
		logic div_last;
		logic mul_last;
	} dp_sts_t;

endpackage

>>> hdl/ttus_ctrl.sv
`timescale 1ns / 1ps

module ttus_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	output logic               out_valid,
	input  logic               out_stall,
	output ttus_pkg::dp_cmd_t  cmd,
	input  ttus_pkg::dp_sts_t  sts
);

	ttus_pkg::state_t state_q;
	ttus_pkg::state_t state_nxt;
	logic             ovalid_q;
	logic             out_free;

	assign out_free = !ovalid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttus_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ttus_pkg::ST_IDLE: begin
				if (in_valid && !cfg_valid) begin
					state_nxt = sts.derived ? ttus_pkg::ST_MUL : ttus_pkg::ST_SEARCH;
				end
			end
			ttus_pkg::ST_SEARCH: begin
				if (sts.fit) begin
					state_nxt = ttus_pkg::ST_DIVIDE;
				end
			end
			ttus_pkg::ST_DIVIDE: begin
				if (sts.div_last) begin
					state_nxt = ttus_pkg::ST_MUL;
				end
			end
			ttus_pkg::ST_MUL: begin
				if (sts.mul_last) begin
					state_nxt = ttus_pkg::ST_SHIFT;
				end
			end
			ttus_pkg::ST_SHIFT: begin
				if (out_free) begin
					state_nxt = ttus_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ttus_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			ttus_pkg::ST_IDLE: begin
				cfg_ready = 1'b1;
				in_stall = cfg_valid;
				cmd.cfg_wr = cfg_valid;
				cmd.start = in_valid && !cfg_valid;
			end
			ttus_pkg::ST_SEARCH: cmd.srch_step = 1'b1;
			ttus_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
			ttus_pkg::ST_MUL: cmd.mul_step = 1'b1;
			ttus_pkg::ST_SHIFT: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	assign out_valid = ovalid_q;

endmodule

>>> hdl/ttus_dp.sv
`timescale 1ns / 1ps

module ttus_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ttus_pkg::dp_cmd_t               cmd,
	output ttus_pkg::dp_sts_t               sts,
	input  logic [ttus_pkg::DATA_W-1:0]     counter_frequency,
	input  logic [ttus_pkg::DATA_W-1:0]     tick_count,
	output logic [ttus_pkg::DATA_W-1:0]     microseconds,
	output logic                            overflowed
);

	logic [63:0]  freq_q;
	logic [63:0]  mult_q;
	logic [6:0]   shift_q;
	logic [83:0]  pow_q;
	logic [6:0]   cnt_q;
	logic [63:0]  rem_q;
	logic [63:0]  num_q;
	logic [63:0]  tick_q;
	logic [127:0] acc_q;
	logic [2:0]   mcnt_q;
	logic [63:0]  prod_s1;
	logic [1:0]   sh_s1;
	logic [63:0]  usec_q;
	logic         ovf_q;

	logic [84:0]  sum_w;
	logic [20:0]  sum_hi;
	logic         fit;
	logic [64:0]  trial;
	logic [64:0]  diff;
	logic         ge;
	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [127:0] shifted;

	// rounded numerator for the current shift and its fit test
	assign sum_w = {1'b0, pow_q} + {22'b0, freq_q[63:1]};
	assign sum_hi = sum_w[84:64];
	assign fit = {43'b0, sum_hi} < freq_q;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, num_q[63]};
	assign ge = trial >= {1'b0, freq_q};
	assign diff = trial - {1'b0, freq_q};

	assign a_half = mcnt_q[0] ? tick_q[63:32] : tick_q[31:0];
	assign b_half = mcnt_q[1] ? mult_q[63:32] : mult_q[31:0];

	assign shifted = acc_q >> shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= ttus_pkg::FREQ_RESET;
			mult_q <= '0;
			shift_q <= '0;
		end else begin
			if (cmd.cfg_wr) begin
				freq_q <= (counter_frequency == 64'd0) ? 64'd1 : counter_frequency;
				mult_q <= '0;
				shift_q <= '0;
			end
			if (cmd.srch_step && fit) begin
				shift_q <= cnt_q;
			end
			if (cmd.div_step) begin
				mult_q <= {mult_q[62:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			tick_q <= tick_count;
			acc_q <= '0;
			mcnt_q <= '0;
			pow_q <= ttus_pkg::POW_INIT;
			cnt_q <= ttus_pkg::MAX_SHIFT;
		end
		if (cmd.srch_step) begin
			if (fit) begin
				rem_q <= {43'b0, sum_hi};
				num_q <= sum_w[63:0];
				cnt_q <= ttus_pkg::DIV_STEPS;
			end else begin
				pow_q <= pow_q >> 1;
				cnt_q <= cnt_q - 7'd1;
			end
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			num_q <= {num_q[62:0], 1'b0};
			cnt_q <= cnt_q - 7'd1;
		end
		if (cmd.mul_step) begin
			prod_s1 <= a_half * b_half;
			sh_s1 <= {1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]};
			mcnt_q <= mcnt_q + 3'd1;
			if (mcnt_q != 3'd0) begin
				acc_q <= acc_q + ({64'b0, prod_s1} << {sh_s1, 5'b0});
			end
		end
		if (cmd.out_load) begin
			usec_q <= shifted[63:0];
			ovf_q <= |shifted[127:64];
		end
	end

	assign sts.derived = shift_q != 7'd0;
	assign sts.fit = fit;
	assign sts.div_last = cnt_q == 7'd1;
	assign sts.mul_last = mcnt_q == ttus_pkg::MUL_LAST;

	assign microseconds = usec_q;
	assign overflowed = ovf_q;

endmodule

>>> hdl/tick_to_microsecond_converter_unit.sv
// once the scale is held, an accepted request goes straight to the multiply steps
// first request after reset or a frequency write adds a shift search and a
// restoring divide, one quotient bit per cycle, to derive the scale
// requests do not overlap: four 32x32 partial products and the accumulate and shift
// stages precede the next one; the result register frees the input side early
// reset: asynchronous active low, frequency 24000000, scale cleared
`timescale 1ns / 1ps

module tick_to_microsecond_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] tick_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] microseconds,
	output logic        overflowed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] counter_frequency
);

	ttus_pkg::dp_cmd_t cmd;
	ttus_pkg::dp_sts_t sts;

	ttus_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	ttus_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.counter_frequency (counter_frequency),
		.tick_count        (tick_count),
		.microseconds      (microseconds),
		.overflowed        (overflowed)
	);

endmodule

>>> hdl/ttus_chk.sv
`timescale 1ns / 1ps
`include "tick_to_microsecond_converter_unit_assert.svh"

module ttus_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] microseconds,
	input logic        overflowed,
	input logic        cfg_ready
);

	// a held result keeps its payload
	`TTUS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(microseconds) && $stable(overflowed))

	// an accepted request makes the block busy
	`TTUS_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall, in_stall)

	// no result can appear the cycle after a request
	`TTUS_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))

	// taking requests implies the config port is open too
	`TTUS_ASSERT_NOW(a_ready_when_open, clk, arst_n, !in_stall, cfg_ready)

endmodule

bind tick_to_microsecond_converter_unit ttus_chk u_chk (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic [63:0] usec;
		logic        ovf;
	} usec_result_t;

	class usec_scoreboard;
		logic [63:0]  frequency;
		logic [63:0]  multiplier;
		logic [6:0]   shift;
		usec_result_t pending_usec[$];
		int unsigned  errors;

		function new();
			frequency = ttus_pkg::FREQ_RESET;
			multiplier = 64'd0;
			shift = 7'd0;
			errors = 0;
		endfunction

		function void write_frequency(logic [63:0] f);
			frequency = (f == 64'd0) ? 64'd1 : f;
			multiplier = 64'd0;
			shift = 7'd0;
		endfunction

		// largest shift whose rounded quotient still fits in 64 bits
		function void derive_scale();
			logic [127:0] numer;
			logic [127:0] quot;
			int s;
			for (s = int'(ttus_pkg::MAX_SHIFT); s > 0; s--) begin
				numer = (128'd1000000 << s) + {64'd0, frequency >> 1};
				quot = numer / {64'd0, frequency};
				multiplier = quot[63:0];
				if (quot[127:64] == 64'd0) begin
					shift = s[6:0];
					break;
				end
			end
			if (shift == 7'd0)
				shift = 7'd1;
		endfunction

		function void note_request(logic [63:0] ticks);
			logic [127:0] prod;
			usec_result_t r;
			if (shift == 7'd0)
				derive_scale();
			prod = ({64'd0, ticks} * {64'd0, multiplier}) >> shift;
			r.usec = prod[63:0];
			r.ovf = |prod[127:64];
			pending_usec.push_back(r);
		endfunction

		function void check_result(logic [63:0] usec, logic ovf);
			usec_result_t e;
			if (pending_usec.size() == 0) begin
				$display("%0t: unexpected result usec %h ovf %b", $time, usec, ovf);
				errors++;
				return;
			end
			e = pending_usec.pop_front();
			if (usec !== e.usec) begin
				$display("%0t: microseconds expected %h actual %h", $time, e.usec, usec);
				errors++;
			end
			if (ovf !== e.ovf) begin
				$display("%0t: overflowed expected %b actual %b", $time, e.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] tick_count;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] microseconds;
	logic        overflowed;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] counter_frequency;

	usec_scoreboard sb = new();
	bit             idling_on;
	int             stall_left;

	tick_to_microsecond_converter_unit uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.tick_count        (tick_count),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.microseconds      (microseconds),
		.overflowed        (overflowed),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.counter_frequency (counter_frequency)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("tick_to_microsecond_converter_unit verification failed");
		$finish;
	end

	// receiver with random stall bursts
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(microseconds, overflowed);

	task automatic drain_results();
		while (sb.pending_usec.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_tick(input logic [63:0] t);
		in_valid <= 1'b1;
		tick_count <= t;
		do @(posedge clk); while (in_stall);
		sb.note_request(t);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end else if ($urandom_range(0, 39) == 0) begin
			in_valid <= 1'b0;
			drain_results();
		end
	endtask

	task automatic write_frequency(input logic [63:0] f);
		in_valid <= 1'b0;
		drain_results();
		cfg_valid <= 1'b1;
		counter_frequency <= f;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_frequency(f);
	endtask

	function automatic logic [63:0] random_ticks();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: v = {$urandom, $urandom};
			1: v = {32'd0, $urandom_range(0, 10000)};
			2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
			default: v = (64'd1 << $urandom_range(0, 63)) - $urandom_range(0, 2);
		endcase
		return v;
	endfunction

	logic [63:0] freq_plan[12];
	int          phase;
	int          n;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		tick_count = 64'd0;
		cfg_valid = 1'b0;
		counter_frequency = 64'd0;
		idling_on = 1'b0;
		freq_plan = '{64'd24000000, 64'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h8000_0000_0000_0000, 64'd1000000, 64'd32768, 64'd19200000,
			64'd1000000000, {$urandom, $urandom}, {$urandom, $urandom} >> $urandom_range(1, 63),
			64'd24000000};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first phase runs on the reset frequency with no write
		send_tick(64'd0);
		send_tick(64'd1);
		send_tick(64'hAAAA_AAAA_AAAA_AAAA);
		send_tick(64'h5555_5555_5555_5555);
		send_tick(64'h0000_0000_FFFF_FFFF);
		for (phase = 0; phase < 12; phase++) begin
			if (phase > 0)
				write_frequency(freq_plan[phase]);
			idling_on = (phase < 11) && (phase % 3 != 1);
			send_tick(64'hFFFF_FFFF_FFFF_FFFF);
			send_tick(64'h8000_0000_0000_0000);
			for (n = 0; n < 86; n++)
				send_tick(random_ticks());
		end
		in_valid <= 1'b0;
		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_usec.size() == 0)
			$display("tick_to_microsecond_converter_unit verification clean");
		else
			$display("tick_to_microsecond_converter_unit verification failed");
		$finish;
	end

endmodule
